/* hw/rtl/utf8sd_pkg.sv */
// Shared types and constants for the UTF-8 strict decoder.
package utf8sd_pkg;

    localparam int CP_W  = 21;
    localparam int CNT_W = 3;

    localparam logic [CP_W-1:0] REPL_CP  = 21'h00FFFD;
    localparam logic [CP_W-1:0] SURR_LO  = 21'h00D800;
    localparam logic [CP_W-1:0] SURR_HI  = 21'h00DFFF;
    localparam logic [CP_W-1:0] MIN_TWO  = 21'h000080;
    localparam logic [CP_W-1:0] MIN_THR  = 21'h000800;
    localparam logic [CP_W-1:0] MIN_FOUR = 21'h010000;

    localparam logic [7:0] CONT_MASK = 8'hC0;
    localparam logic [7:0] CONT_CODE = 8'h80;
    localparam logic [7:0] NUL_BYTE  = 8'h00;

    // Results caused by one input byte: rep_cnt replacements, then an
    // optional decoded code point.
    typedef struct packed {
        logic [CNT_W-1:0] rep_cnt;
        logic             has_cp;
        logic [CP_W-1:0]  cp;
    } burst_t;

endpackage

/* hw/rtl/utf8sd_decode.sv */
// Sequence state and per-byte decode into a result burst descriptor.
module utf8sd_decode
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                take,
    input  logic [7:0]          text_byte,
    output utf8sd_pkg::burst_t  burst
);

    logic [1:0]                  exp_reg, exp_next;
    logic [1:0]                  seen_reg, seen_next;
    logic [utf8sd_pkg::CP_W-1:0] pv_reg, pv_next;

    logic [1:0]                  seen_inc;
    logic [utf8sd_pkg::CP_W-1:0] pv_shift;
    logic [utf8sd_pkg::CP_W-1:0] min_val;
    logic                        is_cont;
    logic                        bad_val;

    always_comb
    begin
        seen_inc = seen_reg + 2'd1;
        pv_shift = {pv_reg[utf8sd_pkg::CP_W-7:0], text_byte[5:0]};
        is_cont  = (text_byte & utf8sd_pkg::CONT_MASK) == utf8sd_pkg::CONT_CODE;
        case (exp_reg)
            2'd1:    min_val = utf8sd_pkg::MIN_TWO;
            2'd2:    min_val = utf8sd_pkg::MIN_THR;
            default: min_val = utf8sd_pkg::MIN_FOUR;
        endcase
        bad_val = (pv_shift < min_val) ||
                  ((pv_shift >= utf8sd_pkg::SURR_LO) && (pv_shift <= utf8sd_pkg::SURR_HI));

        burst     = '0;
        exp_next  = exp_reg;
        seen_next = seen_reg;
        pv_next   = pv_reg;

        if (text_byte == utf8sd_pkg::NUL_BYTE)
        begin
            // terminator: flush whatever is open
            if (exp_reg != 2'd0)
            begin
                burst.rep_cnt = {1'b0, seen_reg} + 3'd1;
            end
            exp_next  = 2'd0;
            seen_next = 2'd0;
            pv_next   = '0;
        end
        else if ((exp_reg != 2'd0) && is_cont)
        begin
            if (seen_inc >= exp_reg)
            begin
                if (bad_val)
                begin
                    burst.rep_cnt = {1'b0, exp_reg} + 3'd1;
                end
                else
                begin
                    burst.has_cp = 1'b1;
                    burst.cp     = pv_shift;
                end
                exp_next  = 2'd0;
                seen_next = 2'd0;
                pv_next   = '0;
            end
            else
            begin
                seen_next = seen_inc;
                pv_next   = pv_shift;
            end
        end
        else
        begin
            // broken sequence: lead plus held tails each give a replacement
            if (exp_reg != 2'd0)
            begin
                burst.rep_cnt = {1'b0, seen_reg} + 3'd1;
            end
            exp_next  = 2'd0;
            seen_next = 2'd0;
            pv_next   = '0;
            // byte taken as a new lead
            if (text_byte < 8'h80)
            begin
                burst.has_cp = 1'b1;
                burst.cp     = {{(utf8sd_pkg::CP_W-8){1'b0}}, text_byte};
            end
            else if (text_byte inside {[8'hC0:8'hDF]})
            begin
                exp_next = 2'd1;
                pv_next  = {{(utf8sd_pkg::CP_W-5){1'b0}}, text_byte[4:0]};
            end
            else if (text_byte inside {[8'hE0:8'hEF]})
            begin
                exp_next = 2'd2;
                pv_next  = {{(utf8sd_pkg::CP_W-4){1'b0}}, text_byte[3:0]};
            end
            else if (text_byte inside {[8'hF0:8'hF7]})
            begin
                exp_next = 2'd3;
                pv_next  = {{(utf8sd_pkg::CP_W-3){1'b0}}, text_byte[2:0]};
            end
            else
            begin
                burst.rep_cnt = burst.rep_cnt + 3'd1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            exp_reg  <= 2'd0;
            seen_reg <= 2'd0;
            pv_reg   <= '0;
        end
        else if (take)
        begin
            exp_reg  <= exp_next;
            seen_reg <= seen_next;
            pv_reg   <= pv_next;
        end
    end

endmodule

/* hw/rtl/utf8sd_emit.sv */
// Skid buffer plus result register that plays out one burst an item at a time.
module utf8sd_emit
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          load,
    input  utf8sd_pkg::burst_t            burst,
    output logic                          room,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [utf8sd_pkg::CP_W-1:0]   code_point,
    output logic                          replaced,
    output logic                          last_of_run
);

    logic                 skid_valid_reg;
    utf8sd_pkg::burst_t   skid_reg;

    logic [utf8sd_pkg::CNT_W-1:0] rep_reg;
    logic                         has_reg;
    logic [utf8sd_pkg::CP_W-1:0]  cp_reg;

    logic out_take;
    logic out_free;

    always_comb
    begin
        out_valid   = (rep_reg != '0) || has_reg;
        replaced    = (rep_reg != '0);
        code_point  = replaced ? utf8sd_pkg::REPL_CP : cp_reg;
        last_of_run = replaced ? ((rep_reg == 3'd1) && !has_reg) : 1'b1;
        out_take    = out_valid && out_ready;
        out_free    = !out_valid || (out_take && last_of_run);
        room        = !skid_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            skid_valid_reg <= 1'b0;
            rep_reg        <= '0;
            has_reg        <= 1'b0;
        end
        else
        begin
            if (skid_valid_reg && out_free)
            begin
                rep_reg        <= skid_reg.rep_cnt;
                has_reg        <= skid_reg.has_cp;
                skid_valid_reg <= 1'b0;
            end
            else if (load && out_free)
            begin
                rep_reg <= burst.rep_cnt;
                has_reg <= burst.has_cp;
            end
            else
            begin
                if (load)
                begin
                    skid_valid_reg <= 1'b1;
                end
                if (out_take)
                begin
                    if (rep_reg != '0)
                    begin
                        rep_reg <= rep_reg - 3'd1;
                    end
                    else
                    begin
                        has_reg <= 1'b0;
                    end
                end
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (skid_valid_reg && out_free)
        begin
            cp_reg <= skid_reg.cp;
        end
        else if (load && out_free)
        begin
            cp_reg <= burst.cp;
        end
        if (load && !out_free)
        begin
            skid_reg <= burst;
        end
    end

endmodule

/* hw/rtl/utf8_strict_decoder.sv */
// Top level of the streaming UTF-8 strict decoder.
//
// Takes one raw byte per item on the slave stream and gives decoded code
// points on the master stream. ASCII passes through; 2-, 3- and 4-byte
// sequences give one code point on their last byte (values up to 0x1FFFFF
// are accepted). Every byte that cannot be decoded gives one U+FFFD with
// tuser set: stray continuations, F8-FF leads, the lead and held tails of a
// sequence broken by a non-continuation byte (which is then decoded as a new
// lead), and every byte of an overlong or surrogate sequence. Byte 00 ends
// the string: it flushes an open sequence as replacements and gives nothing
// for itself. Lead bytes and middle continuations give no result. tlast
// marks the final result of each input byte. One input byte is taken per
// cycle while each byte gives at most one result and the master side is
// ready; a byte giving k results holds the master side until all k are
// taken, and input stalls once the one-item skid buffer behind the result
// register is full. Results are registered. No clearing pass after reset.
module utf8_strict_decoder
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] text_byte
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,   // [20:0] code_point, [23:21] zero
    output logic [0:0]  m_tuser,   // [0] replaced
    output logic        m_tlast
);

    utf8sd_pkg::burst_t          burst;
    logic                        in_take;
    logic                        room;
    logic [utf8sd_pkg::CP_W-1:0] code_point;
    logic                        replaced;

    assign in_take = s_tvalid && room;
    assign s_tready = room;

    // sequence state lives here, advanced on every accepted item
    utf8sd_decode u_decode
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .take      (in_take),
        .text_byte (s_tdata),
        .burst     (burst)
    );

    // only items that cause results go into the output side
    utf8sd_emit u_emit
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .load        (in_take && ((burst.rep_cnt != '0) || burst.has_cp)),
        .burst       (burst),
        .room        (room),
        .out_valid   (m_tvalid),
        .out_ready   (m_tready),
        .code_point  (code_point),
        .replaced    (replaced),
        .last_of_run (m_tlast)
    );

    assign m_tdata = {3'b000, code_point};
    assign m_tuser = replaced;

endmodule

/* bench/utf8_strict_decoder_checker.sv */
// Checker for the UTF-8 strict decoder: predicts each byte's results and compares them.
`timescale 1ns / 100ps

module utf8_strict_decoder_checker
    import utf8sd_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [7:0]  s_tdata,    // [7:0] text_byte
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [23:0] m_tdata,    // [20:0] code_point, [23:21] zero
    input  logic [0:0]  m_tuser,    // [0] replaced
    input  logic        m_tlast,
    output int          fail_count,
    output int          pending,
    output int          glyphs_seen,
    output int          repl_seen
);

    typedef struct packed {
        logic [CP_W-1:0] cp;
        logic            repl;
        logic            last;
    } glyph_t;

    glyph_t glyph_q[$];

    // Open sequence: tails the lead needs, tails taken, payload bits so far.
    logic [1:0]      seq_need = 2'd0;
    logic [1:0]      seq_got  = 2'd0;
    logic [CP_W-1:0] seq_bits = '0;

    int mismatches = 0;
    int n_glyphs   = 0;
    int n_repl     = 0;

    task automatic push_glyph(input logic [CP_W-1:0] cp, input logic repl);
        glyph_q.push_back('{cp: cp, repl: repl, last: 1'b0});
    endtask

    task automatic close_seq();
        seq_need = 2'd0;
        seq_got  = 2'd0;
        seq_bits = '0;
    endtask

    // Lead and held tails each cost one replacement.
    task automatic flush_seq();
        for (int i = 0; i <= seq_got; i++)
            push_glyph(REPL_CP, 1'b1);
        close_seq();
    endtask

    task automatic open_lead(input logic [7:0] b);
        casez (b)
            8'b0???????: push_glyph({13'd0, b}, 1'b0);
            8'b110?????:
            begin
                seq_need = 2'd1;
                seq_got  = 2'd0;
                seq_bits = {16'd0, b[4:0]};
            end
            8'b1110????:
            begin
                seq_need = 2'd2;
                seq_got  = 2'd0;
                seq_bits = {17'd0, b[3:0]};
            end
            8'b11110???:
            begin
                seq_need = 2'd3;
                seq_got  = 2'd0;
                seq_bits = {18'd0, b[2:0]};
            end
            default: push_glyph(REPL_CP, 1'b1);    // stray tail or F8-FF
        endcase
    endtask

    task automatic decode_byte(input logic [7:0] b);
        int              base;
        logic [CP_W-1:0] floor_cp;
        glyph_t          tail_glyph;
        base = glyph_q.size();
        if (b == NUL_BYTE)
        begin
            if (seq_need != 2'd0)
                flush_seq();
        end
        else if (seq_need != 2'd0)
        begin
            if ((b & CONT_MASK) == CONT_CODE)
            begin
                seq_bits = {seq_bits[CP_W-7:0], b[5:0]};
                seq_got  = seq_got + 2'd1;
                if (seq_got >= seq_need)
                begin
                    floor_cp = (seq_need == 2'd1) ? MIN_TWO :
                               (seq_need == 2'd2) ? MIN_THR : MIN_FOUR;
                    // Overlong or surrogate: one replacement per byte.
                    if (seq_bits < floor_cp || (seq_bits >= SURR_LO && seq_bits <= SURR_HI))
                    begin
                        for (int i = 0; i <= seq_need; i++)
                            push_glyph(REPL_CP, 1'b1);
                    end
                    else
                    begin
                        push_glyph(seq_bits, 1'b0);
                    end
                    close_seq();
                end
            end
            else
            begin
                // Broken sequence; the breaking byte starts over as a lead.
                flush_seq();
                open_lead(b);
            end
        end
        else
        begin
            open_lead(b);
        end
        if (glyph_q.size() > base)
        begin
            tail_glyph = glyph_q.pop_back();
            tail_glyph.last = 1'b1;
            glyph_q.push_back(tail_glyph);
        end
    endtask

    task automatic note_failure(input string what);
        mismatches++;
        if (mismatches <= 10)
            $display("%0t ns: %s", $time, what);
    endtask

    always @(posedge clk)
    begin
        glyph_t want;
        if (rst_n)
        begin
            // Results first: a byte taken at this edge cannot show up before the next.
            if (m_tvalid && m_tready)
            begin
                n_glyphs++;
                if (m_tuser[0])
                    n_repl++;
                if (glyph_q.size() == 0)
                begin
                    note_failure($sformatf("unexpected result cp %h rep %b last %b",
                                           m_tdata, m_tuser[0], m_tlast));
                end
                else
                begin
                    want = glyph_q.pop_front();
                    if (m_tdata !== {3'd0, want.cp} || m_tuser[0] !== want.repl ||
                        m_tlast !== want.last)
                        note_failure($sformatf(
                            "mismatch: expected cp %h rep %b last %b, got cp %h rep %b last %b",
                            {3'd0, want.cp}, want.repl, want.last,
                            m_tdata, m_tuser[0], m_tlast));
                end
            end
            if (s_tvalid && s_tready)
                decode_byte(s_tdata);
        end
        fail_count  <= mismatches;
        pending     <= glyph_q.size();
        glyphs_seen <= n_glyphs;
        repl_seen   <= n_repl;
    end

endmodule

/* bench/tb_utf8_strict_decoder.sv */
// Top of the UTF-8 strict decoder bench: clock, reset, byte stimulus and verdict.
`timescale 1ns / 100ps

module tb_utf8_strict_decoder;
    import utf8sd_pkg::*;

    logic        clk      = 1'b0;
    logic        rst_n    = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata  = 8'h00;   // [7:0] text_byte
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [23:0] m_tdata;            // [20:0] code_point, [23:21] zero
    logic [0:0]  m_tuser;            // [0] replaced
    logic        m_tlast;

    int fail_count;
    int pending;
    int glyphs_seen;
    int repl_seen;

    // Random stalls on both sides while set; cleared for the closing stretch.
    logic idle_on    = 1'b1;
    int   bytes_sent = 0;
    int   directed_n = 0;

    // Directed opening: extremes, every sequence length, each rejection case.
    logic [7:0] opening [0:27];

    always #1 clk = ~clk;

    utf8_strict_decoder u_top
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    utf8_strict_decoder_checker u_checker
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser),
        .m_tlast     (m_tlast),
        .fail_count  (fail_count),
        .pending     (pending),
        .glyphs_seen (glyphs_seen),
        .repl_seen   (repl_seen)
    );

    // Sink side: random stall bursts.
    initial
    begin
        forever
        begin
            @(posedge clk);
            if (idle_on && $urandom_range(0, 5) == 0)
            begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 8)) @(posedge clk);
            end
            m_tready <= 1'b1;
        end
    end

    // One byte, with an optional gap ahead of it; returns at the accepting edge.
    task automatic send_byte(input logic [7:0] b);
        if (idle_on && $urandom_range(0, 4) == 0)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        bytes_sent++;
    endtask

    // Hold the source until every predicted result has been taken.
    task automatic drain();
        s_tvalid <= 1'b0;
        do
            @(posedge clk);
        while (pending != 0);
    endtask

    // Encode cp over n tails; values below the minimum give overlong forms.
    task automatic send_seq(input logic [CP_W-1:0] cp, input int n);
        case (n)
            1:
            begin
                send_byte({3'b110, cp[10:6]});
                send_byte({2'b10, cp[5:0]});
            end
            2:
            begin
                send_byte({4'b1110, cp[15:12]});
                send_byte({2'b10, cp[11:6]});
                send_byte({2'b10, cp[5:0]});
            end
            default:
            begin
                send_byte({5'b11110, cp[20:18]});
                send_byte({2'b10, cp[17:12]});
                send_byte({2'b10, cp[11:6]});
                send_byte({2'b10, cp[5:0]});
            end
        endcase
    endtask

    // Lead plus fewer tails than it needs, then a byte that is no tail.
    task automatic send_broken();
        int n;
        int k;
        n = $urandom_range(1, 3);
        k = $urandom_range(0, n - 1);
        case (n)
            1:       send_byte({3'b110, 5'($urandom)});
            2:       send_byte({4'b1110, 4'($urandom)});
            default: send_byte({5'b11110, 3'($urandom)});
        endcase
        repeat (k)
            send_byte({2'b10, 6'($urandom)});
        case ($urandom_range(0, 3))
            0:       send_byte(8'($urandom_range(1, 8'h7F)));
            1:       send_byte(8'($urandom_range(8'hC0, 8'hF7)));
            2:       send_byte(8'($urandom_range(8'hF8, 8'hFF)));
            default: send_byte(NUL_BYTE);
        endcase
    endtask

    initial
    begin
        int pick;
        int n;
        int floor_cp;

        opening = '{
            8'h7F, 8'h00,                   // top ASCII, bare terminator
            8'hE2, 8'h82, 8'hAC,            // three-byte euro sign
            8'hF7, 8'hBF, 8'hBF, 8'hBF,     // largest four-byte value
            8'hC0, 8'h80,                   // overlong two-byte
            8'hED, 8'hA0, 8'h80,            // surrogate
            8'h80, 8'hFF,                   // stray tail, invalid lead
            8'hE2, 8'h82, 8'h41,            // cut short by ASCII
            8'hF0, 8'h9F, 8'h98, 8'hFF,     // cut short by F8-FF: four results
            8'hC2, 8'h00,                   // terminator flushes open lead
            8'hEF, 8'hBF, 8'hBD             // encoded U+FFFD, not a rejection
        };

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (opening[i])
            send_byte(opening[i]);
        directed_n = bytes_sent;
        drain();

        while (bytes_sent < 470)
        begin
            // Alternate stretches with and without stalls; none near the end.
            idle_on <= (bytes_sent < 400) && ((bytes_sent / 50) % 4 != 3);
            if (bytes_sent >= 250 && bytes_sent < 256)
                drain();
            pick = $urandom_range(0, 99);
            if (pick < 25)
            begin
                send_byte(8'($urandom_range(1, 8'h7F)));
            end
            else if (pick < 40)
            begin
                send_seq(CP_W'($urandom_range(MIN_TWO, MIN_THR - 1)), 1);
            end
            else if (pick < 55)
            begin
                send_seq(CP_W'($urandom_range(MIN_THR, MIN_FOUR - 1)), 2);
            end
            else if (pick < 67)
            begin
                send_seq(CP_W'($urandom_range(MIN_FOUR, 21'h1FFFFF)), 3);
            end
            else if (pick < 75)
            begin
                n = $urandom_range(1, 3);
                floor_cp = (n == 1) ? MIN_TWO : (n == 2) ? MIN_THR : MIN_FOUR;
                send_seq(CP_W'($urandom_range(0, floor_cp - 1)), n);
            end
            else if (pick < 80)
            begin
                send_seq(CP_W'($urandom_range(SURR_LO, SURR_HI)), 2);
            end
            else if (pick < 90)
            begin
                send_broken();
            end
            else if (pick < 96)
            begin
                send_byte(8'($urandom));
            end
            else
            begin
                send_byte(NUL_BYTE);
            end
        end

        drain();
        repeat (8) @(posedge clk);

        $display("Sent %0d bytes (%0d directed, rest random sequences and noise).",
                 bytes_sent, directed_n);
        $display("Checked %0d results, %0d of them replacements.", glyphs_seen, repl_seen);
        if (fail_count == 0 && pending == 0)
            $display("PASS utf8_strict_decoder");
        else
            $display("FAIL utf8_strict_decoder");
        $finish;
    end

    // Watchdog: far beyond the slowest correct run.
    initial
    begin
        #400000;
        $display("FAIL utf8_strict_decoder");
        $finish;
    end

endmodule
